FILE: hdl/binomial_coefficient_mod_prime_unit_defines.svh
// assertion macros for the binomial coefficient unit
// used by the top level; expects clk and rst in scope
`ifndef BINOMIAL_COEFFICIENT_MOD_PRIME_UNIT_DEFINES_SVH
`define BINOMIAL_COEFFICIENT_MOD_PRIME_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BCMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BCMP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BCMP_ASSERT(lbl, prop, msg)
`define BCMP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: hdl/bcmp_pkg.sv
// constants, types and montgomery helpers for the binomial coefficient unit
// no dependencies
`default_nettype none
package bcmp_pkg;
  localparam int TABLE_SIZE = 4096;
  localparam int ADDR_W = $clog2(TABLE_SIZE);
  localparam int VAL_W = 30;
  localparam int PROD_W = 2 * VAL_W;
  localparam int MONT_LAT = 4;

  localparam logic [VAL_W-1:0] PRIME = 30'd1000000009;
  // r mod p with r = 2^30
  localparam logic [VAL_W-1:0] R_MOD = 30'd73741815;
  // r^2 mod p
  localparam longint unsigned R2_L = (64'd1 << 60) % 64'd1000000009;
  localparam logic [VAL_W-1:0] R2_MOD = R2_L[VAL_W-1:0];
  localparam logic [VAL_W-1:0] EXP_INIT = PRIME - 30'd2;
  localparam logic [VAL_W-1:0] ONE = 30'd1;
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(TABLE_SIZE - 1);

  // -p^-1 mod 2^30 by newton iteration
  function automatic logic [VAL_W-1:0] mont_nprime();
    logic [VAL_W-1:0] x;
    x = PRIME;
    for (int k = 0; k < 5; k++) begin
      x = x * (30'd2 - PRIME * x);
    end
    return -x;
  endfunction

  localparam logic [VAL_W-1:0] NPRIME = mont_nprime();

  typedef enum logic [2:0] {
    ST_ZERO, ST_FACT, ST_CONV, ST_PMUL, ST_PSQR, ST_LAST, ST_INV, ST_RUN
  } init_state_t;
endpackage
`default_nettype wire

FILE: hdl/bcmp_mont.sv
// pipelined montgomery multiplier modulo the prime, r = 2^30, four stages
// depends on bcmp_pkg
`default_nettype none
module bcmp_mont import bcmp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [VAL_W-1:0] a,
  input  wire logic [VAL_W-1:0] b,
  output logic                  out_valid,
  output logic      [VAL_W-1:0] res
);
  logic [MONT_LAT-2:0] v;
  logic [PROD_W-1:0] t1, t2, t3, mp3;
  logic [VAL_W-1:0] m2;
  logic [PROD_W:0] sum4;
  logic [VAL_W:0] u4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_valid <= 1'b0;
    end else begin
      v <= {v[MONT_LAT-3:0], in_valid};
      out_valid <= v[MONT_LAT-2];
    end
  end

  assign sum4 = {1'b0, t3} + {1'b0, mp3};
  assign u4 = sum4[PROD_W:VAL_W];

  always_ff @(posedge clk) begin
    t1 <= PROD_W'(a) * PROD_W'(b);
    t2 <= t1;
    m2 <= t1[VAL_W-1:0] * NPRIME;
    t3 <= t2;
    mp3 <= PROD_W'(m2) * PROD_W'(PRIME);
    res <= (u4 >= {1'b0, PRIME}) ? VAL_W'(u4 - {1'b0, PRIME}) : u4[VAL_W-1:0];
  end
endmodule
`default_nettype wire

FILE: hdl/binomial_coefficient_mod_prime_unit.sv
// binomial coefficient c(n, r) modulo 1000000009 from factorial tables
// depends on bcmp_pkg, bcmp_mont and the assertion macro header
`default_nettype none
`include "binomial_coefficient_mod_prime_unit_defines.svh"
// usage
//   a query word (total_count = n, choose_count = r) is taken at a rising edge
//   with start high and busy low; the coefficient comes back on coefficient
//   with done high for exactly one cycle, after q1, both multipliers and done
// throughput
//   one query per cycle, back to back: each query reads the factorial table
//   once and the inverse factorial table at two addresses, then runs through
//   two chained four-stage montgomery multipliers
// reset
//   rst (synchronous) starts a start-up pass that fills the factorial table,
//   finds the inverse of the last factorial by square-and-multiply and fills
//   the inverse factorial table backwards; busy stays high for it, and the
//   shared unit finishes each multiplication before it takes the next one
// stalls
//   the receiver cannot hold results off; none are dropped
// r greater than n gives zero
module binomial_coefficient_mod_prime_unit import bcmp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ADDR_W-1:0] total_count,
  input  wire logic [ADDR_W-1:0] choose_count,
  output logic                   done,
  output logic      [VAL_W-1:0]  coefficient
);
  // tables: factorials in plain form, inverse factorials in montgomery form
  logic [VAL_W-1:0] fact_mem [TABLE_SIZE];
  logic [VAL_W-1:0] inv_mem [TABLE_SIZE];

  init_state_t state, state_next;
  logic ready;
  logic pending, issue, take;
  logic fact_we, inv_we;
  logic [ADDR_W-1:0] fact_wa, inv_wa;
  logic [VAL_W-1:0] fact_wd, inv_wd;
  logic [VAL_W-1:0] op_a, op_b;

  // start-up datapath
  logic [ADDR_W-1:0] idx;
  logic [VAL_W-1:0] im, chain, acc, sq, expo;
  logic [VAL_W:0] im_sum, im_dif;
  logic [VAL_W-1:0] im_inc, im_dec;

  // query path
  logic accept;
  logic q1, zq;
  logic [VAL_W-1:0] fact_rd, inv_ra, inv_rb;
  logic [VAL_W-1:0] inv_b_d [MONT_LAT];
  logic [2*MONT_LAT-1:0] zero_d;

  logic u0_in_valid, u0_valid, u1_valid;
  logic [VAL_W-1:0] u0_a, u0_b, u0_res, u1_res;

  assign ready = (state == ST_RUN);
  assign busy = !ready;
  assign accept = start && !busy;
  assign take = pending && u0_valid;

  // i*r mod p stepped up and down
  assign im_sum = {1'b0, im} + {1'b0, R_MOD};
  assign im_inc = (im_sum >= {1'b0, PRIME}) ? VAL_W'(im_sum - {1'b0, PRIME})
                                            : im_sum[VAL_W-1:0];
  assign im_dif = {1'b0, im} - {1'b0, R_MOD};
  assign im_dec = im_dif[VAL_W] ? VAL_W'(im_dif + {1'b0, PRIME}) : im_dif[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ZERO;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    issue = 1'b0;
    fact_we = 1'b0;
    fact_wa = '0;
    fact_wd = ONE;
    inv_we = 1'b0;
    inv_wa = LAST_IDX;
    inv_wd = acc;
    op_a = chain;
    op_b = im;
    unique case (state)
      ST_ZERO: begin
        fact_we = 1'b1;
        state_next = ST_FACT;
      end
      ST_FACT: begin
        issue = !pending;
        if (take) begin
          fact_we = 1'b1;
          fact_wa = idx;
          fact_wd = u0_res;
          if (idx == LAST_IDX) state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        op_b = R2_MOD;
        issue = !pending;
        if (take) state_next = ST_PMUL;
      end
      ST_PMUL: begin
        op_a = acc;
        op_b = sq;
        if (!expo[0]) begin
          state_next = ST_PSQR;
        end else begin
          issue = !pending;
          if (take) state_next = ST_PSQR;
        end
      end
      ST_PSQR: begin
        op_a = sq;
        op_b = sq;
        issue = !pending;
        if (take) state_next = (expo[VAL_W-1:1] == '0) ? ST_LAST : ST_PMUL;
      end
      ST_LAST: begin
        inv_we = 1'b1;
        state_next = ST_INV;
      end
      ST_INV: begin
        issue = !pending;
        if (take) begin
          inv_we = 1'b1;
          inv_wa = idx - 1'b1;
          inv_wd = u0_res;
          if (idx == ADDR_W'(1)) state_next = ST_RUN;
        end
      end
      ST_RUN: begin
      end
      default: begin
        state_next = ST_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (issue) begin
      pending <= 1'b1;
    end else if (take) begin
      pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_ZERO: begin
        chain <= ONE;
        idx <= ADDR_W'(1);
        im <= R_MOD;
      end
      ST_FACT: begin
        if (take) begin
          chain <= u0_res;
          if (idx != LAST_IDX) begin
            idx <= idx + 1'b1;
            im <= im_inc;
          end
        end
      end
      ST_CONV: begin
        if (take) begin
          sq <= u0_res;
          acc <= R_MOD;
          expo <= EXP_INIT;
        end
      end
      ST_PMUL: begin
        if (take) acc <= u0_res;
      end
      ST_PSQR: begin
        if (take) begin
          sq <= u0_res;
          expo <= expo >> 1;
        end
      end
      ST_LAST: begin
        chain <= acc;
      end
      ST_INV: begin
        if (take) begin
          chain <= u0_res;
          idx <= idx - 1'b1;
          im <= im_dec;
        end
      end
      ST_RUN: begin
      end
      default: begin
      end
    endcase
  end

  // table memories, one write port each, inverse table read at r and n-r
  always_ff @(posedge clk) begin
    if (fact_we) fact_mem[fact_wa] <= fact_wd;
    fact_rd <= fact_mem[total_count];
  end

  always_ff @(posedge clk) begin
    if (inv_we) inv_mem[inv_wa] <= inv_wd;
    inv_ra <= inv_mem[choose_count];
    inv_rb <= inv_mem[total_count - choose_count];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q1 <= 1'b0;
      zero_d <= '0;
    end else begin
      q1 <= accept;
      zero_d <= {zero_d[2*MONT_LAT-2:0], zq};
    end
  end

  always_ff @(posedge clk) begin
    zq <= (choose_count > total_count);
    inv_b_d[0] <= inv_rb;
    for (int k = 1; k < MONT_LAT; k++) begin
      inv_b_d[k] <= inv_b_d[k-1];
    end
  end

  // shared unit: start-up chain, then first product of each query
  assign u0_in_valid = q1 || issue;
  assign u0_a = ready ? fact_rd : op_a;
  assign u0_b = ready ? inv_ra : op_b;

  bcmp_mont u_mont0 (
    .clk(clk),
    .rst(rst),
    .in_valid(u0_in_valid),
    .a(u0_a),
    .b(u0_b),
    .out_valid(u0_valid),
    .res(u0_res)
  );

  bcmp_mont u_mont1 (
    .clk(clk),
    .rst(rst),
    .in_valid(u0_valid && ready),
    .a(u0_res),
    .b(inv_b_d[MONT_LAT-1]),
    .out_valid(u1_valid),
    .res(u1_res)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= u1_valid;
    end
    coefficient <= zero_d[2*MONT_LAT-1] ? '0 : u1_res;
  end

  `BCMP_ASSERT(a_latency, accept |-> ##10 done, "result word missing after query")
  `BCMP_ASSERT(a_no_orphan, done |-> $past(accept, 10), "result word without query")
  `BCMP_ASSERT(a_ready_stays, ready |=> ready, "start-up pass restarted without reset")
  `BCMP_ASSERT(a_tables_frozen, ready |-> (!fact_we && !inv_we), "table written after start-up")
  `BCMP_ASSERT(a_mont_range, u0_valid |-> (u0_res < PRIME), "montgomery result not reduced")
endmodule
`default_nettype wire
